@@ src/crc8bs_pkg.sv @@
// Package for the bit-serial CRC generator/checker.
// Holds the shared constants, the register index codes and the queue entry kinds.
// No dependencies.
`timescale 1ns / 1ps

package crc8bs_pkg;

    localparam int CRC_WIDTH_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int POLY_LOW_W      = 8;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int KIND_W          = 2;

    localparam logic [POLY_LOW_W-1:0] POLY_LOW_RESET = 8'h07;
    localparam logic                  MODE_GENERATE  = 1'b0;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MODE     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_POLY_LOW = 1'b1;

    // What the back end has to do for one queued entry.
    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO     = 2'b01,
        KIND_ECHO_CRC = 2'b10,
        KIND_CHECK    = 2'b11
    } kind_t;

endpackage

@@ src/crc8bs_front.sv @@
// Front end: configuration registers, input acceptance and the running remainder.
// Classifies each accepted bit into a queue entry; in check mode only the last bit makes one. Depends on crc8bs_pkg.
`timescale 1ns / 1ps

module crc8bs_front import crc8bs_pkg::*; #(
    parameter int CRC_WIDTH = CRC_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    in_bit,
    input  logic                    in_last,
    output logic                    push_valid,
    input  logic                    push_ready,
    output logic [CRC_WIDTH+3:0]    push_data
);

    logic                  mode_reg, mode_next;
    logic [POLY_LOW_W-1:0] poly_low_reg, poly_low_next;
    logic [CRC_WIDTH-1:0]  rem_reg, rem_next;
    logic [CRC_WIDTH-1:0]  poly_w;
    logic [CRC_WIDTH-1:0]  rem_upd;
    logic                  top;
    logic                  accept;
    kind_t                 kind;
    logic                  ok;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;
    assign poly_w   = CRC_WIDTH'(poly_low_reg);
    assign top      = rem_reg[CRC_WIDTH-1];

    always_comb begin
        mode_next     = mode_reg;
        poly_low_next = poly_low_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MODE:     mode_next     = cfg_wdata[0];
                REG_POLY_LOW: poly_low_next = cfg_wdata[POLY_LOW_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        if (mode_reg == MODE_GENERATE) begin
            // Direct (non-augmented) division: the message bit enters through the feedback tap.
            rem_upd = rem_reg << 1;
            if (top ^ in_bit) begin
                rem_upd = rem_upd ^ poly_w;
            end
            kind = in_last ? KIND_ECHO_CRC : KIND_ECHO;
        end else begin
            rem_upd = (rem_reg << 1) | CRC_WIDTH'(in_bit);
            if (top) begin
                rem_upd = rem_upd ^ poly_w;
            end
            kind = KIND_CHECK;
        end
        ok = (rem_upd == '0);
    end

    // Check mode only produces a result on the last bit.
    assign push_valid = s_tvalid && ((mode_reg == MODE_GENERATE) || in_last);
    assign push_data  = {kind, in_bit, ok, rem_upd};

    always_comb begin
        rem_next = rem_reg;
        if (accept) begin
            rem_next = in_last ? '0 : rem_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_GENERATE;
            poly_low_reg <= POLY_LOW_RESET;
            rem_reg      <= '0;
        end else begin
            mode_reg     <= mode_next;
            poly_low_reg <= poly_low_next;
            rem_reg      <= rem_next;
        end
    end

endmodule

@@ src/crc8bs_queue.sv @@
// Small register FIFO between the front and back ends.
// Generic in width and depth. Depends on crc8bs_pkg for its default width and depth.
`timescale 1ns / 1ps

module crc8bs_queue import crc8bs_pkg::*; #(
    parameter int DATA_W = CRC_WIDTH_DEF + 4,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/crc8bs_back.sv @@
// Back end: turns queue entries into result transactions in an output register.
// Shifts out the CRC bits after a generate-mode last bit. Depends on crc8bs_pkg.
`timescale 1ns / 1ps

module crc8bs_back import crc8bs_pkg::*; #(
    parameter int CRC_WIDTH = CRC_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [CRC_WIDTH+3:0]  pop_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  out_bit,
    output logic                  out_last,
    output logic                  check_ok
);

    localparam int CNT_W = $clog2(CRC_WIDTH + 1);

    logic                 valid_reg, valid_next;
    logic                 bit_reg, bit_next;
    logic                 last_reg, last_next;
    logic                 ok_reg, ok_next;
    logic [CRC_WIDTH-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 adv;
    kind_t                e_kind;
    logic                 e_bit;
    logic                 e_ok;
    logic [CRC_WIDTH-1:0] e_rem;

    assign e_kind = kind_t'(pop_data[CRC_WIDTH+3:CRC_WIDTH+2]);
    assign e_bit  = pop_data[CRC_WIDTH+1];
    assign e_ok   = pop_data[CRC_WIDTH];
    assign e_rem  = pop_data[CRC_WIDTH-1:0];

    assign adv       = !valid_reg || m_tready;
    assign pop_ready = adv && (cnt_reg == '0);

    always_comb begin
        valid_next = valid_reg;
        bit_next   = bit_reg;
        last_next  = last_reg;
        ok_next    = ok_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (adv) begin
            if (cnt_reg != '0) begin
                // CRC bits go out most significant first.
                valid_next = 1'b1;
                bit_next   = shift_reg[CRC_WIDTH-1];
                last_next  = (cnt_reg == CNT_W'(1));
                ok_next    = 1'b0;
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
            end else if (pop_valid) begin
                valid_next = 1'b1;
                case (e_kind)
                    KIND_ECHO: begin
                        bit_next  = e_bit;
                        last_next = 1'b0;
                        ok_next   = 1'b0;
                    end
                    KIND_ECHO_CRC: begin
                        bit_next   = e_bit;
                        last_next  = 1'b0;
                        ok_next    = 1'b0;
                        shift_next = e_rem;
                        cnt_next   = CNT_W'(CRC_WIDTH);
                    end
                    KIND_CHECK: begin
                        bit_next  = 1'b0;
                        last_next = 1'b1;
                        ok_next   = e_ok;
                    end
                    default: begin
                        bit_next  = 1'b0;
                        last_next = 1'b0;
                        ok_next   = 1'b0;
                    end
                endcase
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg   <= bit_next;
        last_reg  <= last_next;
        ok_reg    <= ok_next;
        shift_reg <= shift_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign out_bit  = bit_reg;
    assign out_last = last_reg;
    assign check_ok = ok_reg;

endmodule

@@ src/crc8_bit_serial_gen_check_unit.sv @@
// Bit-serial CRC generator/checker, MSB first, zero init, no reflection, no final xor.
// Each result passes through the queue and then the back-end output register.
// Throughput: one input bit per cycle while s_tready is high (the queue is not full);
// after a generate-mode last bit the back end sends the CRC_WIDTH CRC bits and pops no
// entries meanwhile, so with the result side ready s_tready drops once the queue fills.
// Reset (synchronous, aresetn low): remainder 0, mode generate, poly 0x07, queue empty.
`timescale 1ns / 1ps

module crc8_bit_serial_gen_check_unit import crc8bs_pkg::*; #(
    parameter int CRC_WIDTH   = CRC_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] in_bit, [7:1] zero
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] out_bit, [1] check_ok, [7:2] zero
    output logic                  m_tlast
);

    localparam int ENTRY_W = CRC_WIDTH + 4;

    logic               push_valid, push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid, pop_ready;
    logic [ENTRY_W-1:0] pop_data;
    logic               out_bit, check_ok;

    crc8bs_front #(
        .CRC_WIDTH(CRC_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_bit    (s_tdata[0]),
        .in_last   (s_tlast),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data)
    );

    crc8bs_queue #(
        .DATA_W(ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data (push_data),
        .rd_valid(pop_valid),
        .rd_ready(pop_ready),
        .rd_data (pop_data)
    );

    crc8bs_back #(
        .CRC_WIDTH(CRC_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_bit  (out_bit),
        .out_last (m_tlast),
        .check_ok (check_ok)
    );

    assign m_tdata = {6'b0, check_ok, out_bit};

endmodule
